FILE: rtl/assert_macros.svh
// Assertion macros for the RTL files of the stepper position controller.
// No dependencies; included by the modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic check on an explicit clock and active-low reset.
`define SPC_ASSERT_AT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on the default clk_i / rst_ni pair.
`define SPC_ASSERT(name, prop, msg) \
  `SPC_ASSERT_AT(name, clk_i, rst_ni, prop, msg)

`endif

FILE: rtl/spc_pkg.sv
// Package for the stepper position controller: widths, codes and the
// request/status structs between the sequencer and its serial units.
package spc_pkg;

  localparam int NUM_W     = 25;  // dividend / product width
  localparam int DEN_W     = 9;   // divisor width
  localparam int CNT_W     = 5;   // divider iteration counter
  localparam int MAG_W     = 17;  // error magnitude in cdeg
  localparam int EDEG_W    = 10;  // error in whole degrees
  localparam int PER_W     = 16;  // step period
  localparam int MUL_B_W   = 9;   // multiplier operand (clamped degrees)
  localparam int MUL_CNT_W = 4;
  localparam int POS_W     = 32;

  localparam logic [DEN_W-1:0]     CDEG_PER_DEG = 9'd100;
  localparam logic signed [16:0]   SP_CLAMP_POS = 17'sd4000;
  localparam logic signed [16:0]   SP_CLAMP_NEG = -17'sd4000;
  localparam logic [CNT_W-1:0]     ITER_DEG     = 5'd17;
  localparam logic [CNT_W-1:0]     ITER_LIM     = 5'd25;
  localparam logic [MUL_CNT_W-1:0] ITER_MUL     = 4'd9;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_STEP   = 1'b1;

  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_START   = 2'd1;
  localparam logic [1:0] ACT_STOP    = 2'd2;
  localparam logic [1:0] ACT_REVERSE = 2'd3;

  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_DEADBAND = 3'd1;
  localparam logic [2:0] REG_ERR_LIM  = 3'd2;
  localparam logic [2:0] REG_P_SLOW   = 3'd3;
  localparam logic [2:0] REG_P_FAST   = 3'd4;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [CNT_W-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic               start;
    logic [PER_W-1:0]   mcand;
    logic [MUL_B_W-1:0] mplier;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

FILE: rtl/stepper_position_speed_control.sv
// Stepper position controller with deadband and inverse error-to-period law.
// A control update (op 0) uses the shared bit-serial divider (17 iterations for
// the whole-degree error, 25 for the division by the error limit) and the
// 9-step shift-add multiplier; inside the deadband only the first divide runs.
// The next item is taken in the cycle after a result is loaded. One item is
// worked on at a time; the result sits in an output register, so the next item
// is taken while an earlier result waits. Configuration writes are never
// stalled.
`include "assert_macros.svh"

module stepper_position_speed_control import spc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [2:0]              cfg_index_i,
  input  logic [15:0]             cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    op_i,
  input  logic signed [15:0]      setpoint_cdeg_i,
  input  logic signed [16:0]      measured_cdeg_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    moving_o,
  output logic                    dir_out_o,
  output logic [PER_W-1:0]        period_out_o,
  output logic [PER_W-2:0]        compare_out_o,
  output logic [1:0]              action_o,
  output logic signed [POS_W-1:0] step_count_o
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_ERR    = 4'd1;
  localparam logic [3:0] ST_ABS    = 4'd2;
  localparam logic [3:0] ST_DIVDEG = 4'd3;
  localparam logic [3:0] ST_DEC    = 4'd4;
  localparam logic [3:0] ST_MUL    = 4'd5;
  localparam logic [3:0] ST_DIVLIM = 4'd6;
  localparam logic [3:0] ST_PER    = 4'd7;
  localparam logic [3:0] ST_STEP   = 4'd8;
  localparam logic [3:0] ST_DONE   = 4'd9;

  // configuration
  logic             mode_q;
  logic [5:0]       db_q;
  logic [8:0]       lim_cfg_q;
  logic [PER_W-1:0] slow_q, fast_q;

  // control state
  logic [3:0]       state_q, state_d;
  logic             run_q, run_d, dir_q, dir_d;
  logic [PER_W-1:0] period_q, period_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             out_valid_q, out_valid_d;

  // datapath
  logic signed [15:0] sp_q;
  logic signed [16:0] ms_q;
  logic signed [16:0] sp_ext, sp_c;
  logic signed [17:0] err_q, err_d;
  logic [17:0]        err_neg;
  logic [MAG_W-1:0]   mag_q, mag_d;
  logic               pos_err_q, pos_err_d;
  logic [PER_W-1:0]   diff_q, diff_d, slow_lat_q;
  logic               fast_gt_q, fast_gt_d;
  logic [DEN_W-1:0]   lim_q, lim_eff;
  logic [1:0]         action_q, action_d;
  logic [EDEG_W-1:0]  e_deg;
  logic [MUL_B_W-1:0] e_clamp;
  logic [12:0]        db_cdeg;
  logic               in_band, load_out;

  // output register
  logic             o_run_q, o_dir_q;
  logic [PER_W-1:0] o_period_q;
  logic [1:0]       o_action_q;
  logic [POS_W-1:0] o_pos_q;

  div_req_t         div_req;
  mul_req_t         mul_req;
  unit_stat_t       div_stat, mul_stat;
  logic [NUM_W-1:0] div_quot, mul_prod;

  spc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .stat_o (div_stat),
    .quot_o (div_quot)
  );

  spc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .stat_o (mul_stat),
    .prod_o (mul_prod)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      db_q      <= 6'd1;
      lim_cfg_q <= 9'd40;
      slow_q    <= 16'd1000;
      fast_q    <= 16'd100;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MODE:     mode_q    <= cfg_data_i[0];
        REG_DEADBAND: db_q      <= cfg_data_i[5:0];
        REG_ERR_LIM:  lim_cfg_q <= cfg_data_i[8:0];
        REG_P_SLOW:   slow_q    <= cfg_data_i;
        REG_P_FAST:   fast_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // combinational datapath pieces
  always_comb begin
    sp_ext = {sp_q[15], sp_q};
    sp_c   = sp_ext;
    if (mode_q) begin
      if (sp_ext > SP_CLAMP_POS) begin
        sp_c = SP_CLAMP_POS;
      end else if (sp_ext < SP_CLAMP_NEG) begin
        sp_c = SP_CLAMP_NEG;
      end
    end
    err_d     = {sp_c[16], sp_c} - {ms_q[16], ms_q};
    err_neg   = 18'd0 - err_q;
    mag_d     = err_q[17] ? err_neg[MAG_W-1:0] : err_q[MAG_W-1:0];
    pos_err_d = !err_q[17] && (err_q != '0);
    fast_gt_d = fast_q > slow_q;
    diff_d    = fast_gt_d ? '0 : (slow_q - fast_q);
    e_deg     = div_quot[EDEG_W-1:0];
    db_cdeg   = {7'b0, db_q} * 13'd100;
    in_band   = mode_q ? (mag_q <= {4'b0, db_cdeg}) : (e_deg <= {4'b0, db_q});
    lim_eff   = (lim_cfg_q == '0) ? DEN_W'(1) : lim_cfg_q;
    e_clamp   = (e_deg > {1'b0, lim_eff}) ? lim_eff : e_deg[MUL_B_W-1:0];
  end

  always_comb begin
    state_d     = state_q;
    run_d       = run_q;
    dir_d       = dir_q;
    period_d    = period_q;
    pos_d       = pos_q;
    action_d    = action_q;
    out_valid_d = out_valid_q && !out_ready_i;
    load_out    = 1'b0;
    div_req     = '0;
    mul_req     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (op_i == OP_STEP) ? ST_STEP : ST_ERR;
        end
      end
      ST_ERR: state_d = ST_ABS;
      ST_ABS: begin
        div_req.start = 1'b1;
        div_req.num   = {mag_d, {(NUM_W-MAG_W){1'b0}}};
        div_req.den   = CDEG_PER_DEG;
        div_req.iters = ITER_DEG;
        state_d       = ST_DIVDEG;
      end
      ST_DIVDEG: begin
        if (div_stat.done) begin
          state_d = ST_DEC;
        end
      end
      ST_DEC: begin
        if (in_band) begin
          action_d = run_q ? ACT_STOP : ACT_NONE;
          run_d    = 1'b0;
          state_d  = ST_DONE;
        end else begin
          if (!run_q) begin
            action_d = ACT_START;
          end else if (pos_err_q != dir_q) begin
            action_d = ACT_REVERSE;
          end else begin
            action_d = ACT_NONE;
          end
          run_d          = 1'b1;
          dir_d          = pos_err_q;
          mul_req.start  = 1'b1;
          mul_req.mcand  = diff_q;
          mul_req.mplier = e_clamp;
          state_d        = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_stat.done) begin
          div_req.start = 1'b1;
          div_req.num   = mul_prod;
          div_req.den   = lim_q;
          div_req.iters = ITER_LIM;
          state_d       = ST_DIVLIM;
        end
      end
      ST_DIVLIM: begin
        if (div_stat.done) begin
          state_d = ST_PER;
        end
      end
      ST_PER: begin
        period_d = fast_gt_q ? slow_lat_q : (slow_lat_q - div_quot[PER_W-1:0]);
        state_d  = ST_DONE;
      end
      ST_STEP: begin
        action_d = ACT_NONE;
        if (run_q) begin
          pos_d = dir_q ? (pos_q + 32'd1) : (pos_q - 32'd1);
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_q       <= 1'b0;
      dir_q       <= 1'b0;
      period_q    <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_q       <= run_d;
      dir_q       <= dir_d;
      period_q    <= period_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q <= action_d;
    if (in_valid_i && in_ready_o) begin
      sp_q <= setpoint_cdeg_i;
      ms_q <= measured_cdeg_i;
    end
    if (state_q == ST_ERR) begin
      err_q <= err_d;
    end
    if (state_q == ST_ABS) begin
      mag_q      <= mag_d;
      pos_err_q  <= pos_err_d;
      diff_q     <= diff_d;
      fast_gt_q  <= fast_gt_d;
      slow_lat_q <= slow_q;
    end
    if (state_q == ST_DEC) begin
      lim_q <= lim_eff;
    end
    if (load_out) begin
      o_run_q    <= run_q;
      o_dir_q    <= dir_q;
      o_period_q <= period_q;
      o_action_q <= action_q;
      o_pos_q    <= pos_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign moving_o      = o_run_q;
  assign dir_out_o     = o_dir_q;
  assign period_out_o  = o_period_q;
  assign compare_out_o = o_period_q[PER_W-1:1];
  assign action_o      = o_action_q;
  assign step_count_o  = o_pos_q;

  `SPC_ASSERT(a_div_done_state, div_stat.done |-> (state_q == ST_DIVDEG || state_q == ST_DIVLIM), "divider finished outside a divide state")
  `SPC_ASSERT(a_mul_done_state, mul_stat.done |-> (state_q == ST_MUL), "multiplier finished outside the multiply state")
  `SPC_ASSERT(a_quot_bound, (state_q == ST_PER && !fast_gt_q) |-> (div_quot[NUM_W-1:PER_W] == '0 && div_quot[PER_W-1:0] <= diff_q), "speed quotient exceeds period span")
  `SPC_ASSERT(a_start_moving, (out_valid_o && (action_o == ACT_START || action_o == ACT_REVERSE)) |-> moving_o, "start reported while idle")

endmodule

FILE: rtl/spc_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, MSB first.
// Depends on spc_pkg for widths and the request/status structs.
module spc_div import spc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  output unit_stat_t       stat_o,
  output logic [NUM_W-1:0] quot_o
);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] num_q, quo_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [DEN_W:0]   trial, trial_sub;
  logic             ge;

  assign trial     = {rem_q, num_q[NUM_W-1]};
  assign ge        = trial >= {1'b0, den_q};
  assign trial_sub = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.iters;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], 1'b0};
      rem_q <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;

endmodule

FILE: rtl/spc_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, LSB first.
// Depends on spc_pkg for widths and the request/status structs.
module spc_mul import spc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mul_req_t         req_i,
  output unit_stat_t       stat_o,
  output logic [NUM_W-1:0] prod_o
);

  logic                 busy_q, done_q;
  logic [MUL_CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0]     acc_q, mcand_q;
  logic [MUL_B_W-1:0]   mplier_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= ITER_MUL;
      end else if (busy_q) begin
        cnt_q <= cnt_q - MUL_CNT_W'(1);
        if (cnt_q == MUL_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q    <= '0;
      mcand_q  <= NUM_W'(req_i.mcand);
      mplier_q <= req_i.mplier;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q  <= {mcand_q[NUM_W-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[MUL_B_W-1:1]};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_o      = acc_q;

endmodule
